/* rtl/core/sfla_pkg.sv */
// Shared types and codes of the sorted free-list key allocator.
package sfla_pkg;

  localparam int KEY_BITS = 20;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_CLAIM   = 2'd2,
    ACT_MARK    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_DUP_REFUSED = 3'd1,
    ST_DUP_ERROR   = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_INVALID     = 3'd4,
    ST_FULL        = 3'd5,
    ST_EXHAUSTED   = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_SRCH_RD,
    S_SRCH_WT,
    S_SRCH_CMP,
    S_DECIDE,
    S_POP_RD,
    S_POP_WT,
    S_SHIFT_RD,
    S_SHIFT_WT,
    S_SHIFT_WR,
    S_FINISH,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    ADDR_MID,
    ADDR_IDX,
    ADDR_LAST
  } addr_sel_t;

  // Controller to datapath.
  typedef struct packed {
    logic      load;
    logic      srch_init;
    logic      srch_step;
    logic      pop_take;
    logic      idx_init_ins;
    logic      idx_init_del;
    logic      idx_step_ins;
    logic      idx_step_del;
    logic      wr_shift;
    logic      wr_key;
    addr_sel_t addr_sel;
    logic      commit;
    logic      out_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic     pool_bad;
    logic     srch_done;
    logic     found;
    logic     cnt_zero;
    logic     cnt_full;
    logic     idx_done_ins;
    logic     idx_done_del;
    status_t  early_status;
    logic     early_valid;
    logic     need_search;
    logic     dup_allowed;
  } stat_t;

endpackage

/* rtl/core/sorted_free_list_id_allocator_unit.sv */
// Top level of the sorted free-list key allocator.
// Use: present action, pool and key on the in_ channel with in_valid; the
// block takes one item at a time (in_ready high only when idle) and then
// returns one result item on the out_ channel with out_valid.
// Sequence, from the accepting edge: refusals decided from the request and
// pool registers go from S_LOAD straight to the output register; allocate
// from the next key, mark used and release of the key just below the next
// key pass through S_FINISH; allocate from the free list first reads the
// last entry (S_POP_RD, S_POP_WT). Release and claim run a binary search,
// each probe in S_SRCH_RD, S_SRCH_WT and S_SRCH_CMP (P probes, up to
// log2(FREE_DEPTH)+1), then move one entry per S_SHIFT_RD, S_SHIFT_WT,
// S_SHIFT_WR pass through the single RAM port; a duplicate, full-list or
// not-found outcome after the search goes from S_DECIDE to the output.
// Reset: every pool returns to next key 1 with an empty free list; the RAM
// holds no cleared contents and needs no clearing pass.
// Stall: the result is held in the output register until out_ready; no
// new item is taken meanwhile.
// cfg_we writes duplicates_allowed from cfg_wdata; write only when idle.
module sorted_free_list_id_allocator_unit #(
  parameter int FREE_DEPTH = 64,
  parameter int NUM_POOLS  = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_pool,
  input  logic [19:0] in_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] out_granted_key,
  output logic [2:0]  out_status,
  output logic [19:0] out_live_count,
  output logic [19:0] out_next_key
);

  sfla_pkg::cmd_t    cmd;
  sfla_pkg::stat_t   st;
  sfla_pkg::action_t act;

  sfla_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .act(act), .st(st), .cmd(cmd)
  );

  sfla_dpath #(
    .FREE_DEPTH(FREE_DEPTH), .NUM_POOLS(NUM_POOLS)
  ) u_dpath (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_action(in_action), .in_pool(in_pool), .in_key(in_key),
    .cmd(cmd), .st(st), .act(act),
    .out_granted_key(out_granted_key), .out_status(out_status),
    .out_live_count(out_live_count), .out_next_key(out_next_key)
  );

endmodule

/* rtl/core/sfla_ram.sv */
// Generic single-port RAM with registered read.
module sfla_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 320
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/core/sfla_ctrl.sv */
// Sequencer of the sorted free-list key allocator.
module sfla_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  sfla_pkg::action_t act,
  input  sfla_pkg::stat_t st,
  output sfla_pkg::cmd_t  cmd
);

  sfla_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfla_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.addr_sel = sfla_pkg::ADDR_MID;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      sfla_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = sfla_pkg::S_LOAD;
        end
      end
      sfla_pkg::S_LOAD: begin
        if (st.early_valid) begin
          cmd.out_load = 1'b1;
          state_nxt = sfla_pkg::S_OUT;
        end else if (act == sfla_pkg::ACT_ALLOC && !st.cnt_zero) begin
          state_nxt = sfla_pkg::S_POP_RD;
        end else if (st.need_search) begin
          cmd.srch_init = 1'b1;
          state_nxt = sfla_pkg::S_SRCH_RD;
        end else begin
          state_nxt = sfla_pkg::S_FINISH;
        end
      end
      sfla_pkg::S_POP_RD: begin
        cmd.addr_sel = sfla_pkg::ADDR_LAST;
        state_nxt = sfla_pkg::S_POP_WT;
      end
      sfla_pkg::S_POP_WT: begin
        cmd.pop_take = 1'b1;
        state_nxt = sfla_pkg::S_FINISH;
      end
      sfla_pkg::S_SRCH_RD: begin
        if (st.srch_done) begin
          state_nxt = sfla_pkg::S_DECIDE;
        end else begin
          state_nxt = sfla_pkg::S_SRCH_WT;
        end
      end
      sfla_pkg::S_SRCH_WT: state_nxt = sfla_pkg::S_SRCH_CMP;
      sfla_pkg::S_SRCH_CMP: begin
        cmd.srch_step = 1'b1;
        state_nxt = sfla_pkg::S_SRCH_RD;
      end
      sfla_pkg::S_DECIDE: begin
        cmd.addr_sel = sfla_pkg::ADDR_IDX;
        if (act == sfla_pkg::ACT_RELEASE) begin
          if (st.found || st.cnt_full) begin
            cmd.out_load = 1'b1;
            state_nxt = sfla_pkg::S_OUT;
          end else begin
            cmd.idx_init_ins = 1'b1;
            state_nxt = sfla_pkg::S_SHIFT_RD;
          end
        end else if (!st.found) begin
          cmd.out_load = 1'b1;
          state_nxt = sfla_pkg::S_OUT;
        end else begin
          cmd.idx_init_del = 1'b1;
          state_nxt = sfla_pkg::S_SHIFT_RD;
        end
      end
      sfla_pkg::S_SHIFT_RD: begin
        cmd.addr_sel = sfla_pkg::ADDR_IDX;
        if (act == sfla_pkg::ACT_RELEASE && st.idx_done_ins) begin
          cmd.wr_key = 1'b1;
          state_nxt = sfla_pkg::S_FINISH;
        end else if (act != sfla_pkg::ACT_RELEASE && st.idx_done_del) begin
          state_nxt = sfla_pkg::S_FINISH;
        end else begin
          state_nxt = sfla_pkg::S_SHIFT_WT;
        end
      end
      sfla_pkg::S_SHIFT_WT: begin
        cmd.addr_sel = sfla_pkg::ADDR_IDX;
        state_nxt = sfla_pkg::S_SHIFT_WR;
      end
      sfla_pkg::S_SHIFT_WR: begin
        cmd.addr_sel = sfla_pkg::ADDR_IDX;
        cmd.wr_shift = 1'b1;
        if (act == sfla_pkg::ACT_RELEASE) begin
          cmd.idx_step_ins = 1'b1;
        end else begin
          cmd.idx_step_del = 1'b1;
        end
        state_nxt = sfla_pkg::S_SHIFT_RD;
      end
      sfla_pkg::S_FINISH: begin
        cmd.commit = 1'b1;
        cmd.out_load = 1'b1;
        state_nxt = sfla_pkg::S_OUT;
      end
      sfla_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = sfla_pkg::S_IDLE;
        end
      end
      default: state_nxt = sfla_pkg::S_IDLE;
    endcase
  end

endmodule

/* rtl/core/sfla_dpath.sv */
// Pool registers, free-key memory and search/shift datapath.
module sfla_dpath #(
  parameter int FREE_DEPTH = 64,
  parameter int NUM_POOLS  = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic [1:0]        in_action,
  input  logic [2:0]        in_pool,
  input  logic [19:0]       in_key,
  input  sfla_pkg::cmd_t    cmd,
  output sfla_pkg::stat_t   st,
  output sfla_pkg::action_t act,
  output logic [19:0]       out_granted_key,
  output logic [2:0]        out_status,
  output logic [19:0]       out_live_count,
  output logic [19:0]       out_next_key
);

  localparam int CW = $clog2(FREE_DEPTH + 1);
  localparam int IW = $clog2(FREE_DEPTH);
  localparam int PW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int DEPTH = NUM_POOLS * FREE_DEPTH;
  localparam int AW = $clog2(DEPTH);
  localparam logic [20:0] KMASK = 21'((64'd1 << sfla_pkg::KEY_BITS) - 64'd1);

  logic [19:0] nxt_r [NUM_POOLS];
  logic [CW-1:0] cnt_r [NUM_POOLS];
  logic dup_r;

  sfla_pkg::action_t act_r;
  logic [PW-1:0] pool_r;
  logic [19:0] key_r, nx_r, gr_r;
  logic [CW-1:0] cn_r, lo_r, hi_r, idx_r;
  logic pool_bad_r;

  logic [CW-1:0] mid;
  logic [CW-1:0] idx_sel;
  logic [AW-1:0] addr;
  logic we;
  logic [19:0] wdata, rdata;
  logic [19:0] cur_nx;
  logic [CW-1:0] cur_cn;

  assign act = act_r;
  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  always_comb begin
    unique case (cmd.addr_sel)
      sfla_pkg::ADDR_MID:  idx_sel = mid;
      sfla_pkg::ADDR_LAST: idx_sel = cn_r - 1'b1;
      default: begin
        if (act_r == sfla_pkg::ACT_RELEASE && cmd.wr_shift) begin
          idx_sel = idx_r;
        end else if (act_r == sfla_pkg::ACT_RELEASE && !cmd.wr_key) begin
          idx_sel = idx_r - 1'b1;
        end else if (act_r == sfla_pkg::ACT_RELEASE) begin
          idx_sel = idx_r;
        end else if (cmd.wr_shift) begin
          idx_sel = idx_r;
        end else begin
          idx_sel = idx_r + 1'b1;
        end
      end
    endcase
  end

  assign addr = AW'(pool_r * FREE_DEPTH) + AW'(idx_sel[IW-1:0]);
  assign we = cmd.wr_shift | cmd.wr_key;
  assign wdata = cmd.wr_key ? key_r : rdata;

  sfla_ram #(.WIDTH(20), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_comb begin
    cur_nx = nxt_r[in_pool[PW-1:0]];
    cur_cn = cnt_r[in_pool[PW-1:0]];
  end

  // search and shift flags; early outcome decided from the latched request and pool registers alone
  always_comb begin
    st = '0;
    st.pool_bad = pool_bad_r;
    st.srch_done = (lo_r >= hi_r);
    st.found = (lo_r < cn_r) && (rdata == key_r);
    st.cnt_zero = (cn_r == '0);
    st.cnt_full = (cn_r >= CW'(FREE_DEPTH));
    st.idx_done_ins = (idx_r <= lo_r);
    st.idx_done_del = (idx_r + 1'b1 >= cn_r);
    st.dup_allowed = dup_r;
    st.early_valid = 1'b0;
    st.early_status = sfla_pkg::ST_OK;
    st.need_search = 1'b0;
    if (pool_bad_r) begin
      st.early_valid = 1'b1;
      st.early_status = sfla_pkg::ST_INVALID;
    end else begin
      unique case (act_r)
        sfla_pkg::ACT_ALLOC: begin
          if (cn_r == '0 && {1'b0, nx_r} >= KMASK) begin
            st.early_valid = 1'b1;
            st.early_status = sfla_pkg::ST_EXHAUSTED;
          end
        end
        sfla_pkg::ACT_RELEASE: begin
          if ({1'b0, key_r} > KMASK || key_r == '0) begin
            st.early_valid = 1'b1;
            st.early_status = sfla_pkg::ST_INVALID;
          end else if ({1'b0, key_r} + 21'd1 == {1'b0, nx_r}) begin
            st.need_search = 1'b0;
          end else if (key_r >= nx_r) begin
            st.early_valid = 1'b1;
            st.early_status = sfla_pkg::ST_INVALID;
          end else begin
            st.need_search = 1'b1;
          end
        end
        sfla_pkg::ACT_CLAIM: begin
          if ({1'b0, key_r} > KMASK || key_r == '0) begin
            st.early_valid = 1'b1;
            st.early_status = sfla_pkg::ST_INVALID;
          end else begin
            st.need_search = 1'b1;
          end
        end
        default: begin
          if ({1'b0, key_r} > KMASK) begin
            st.early_valid = 1'b1;
            st.early_status = sfla_pkg::ST_INVALID;
          end else if ({1'b0, key_r} == KMASK) begin
            st.early_valid = 1'b1;
            st.early_status = sfla_pkg::ST_EXHAUSTED;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dup_r <= 1'b0;
    end else if (cfg_we) begin
      dup_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= sfla_pkg::action_t'(in_action);
      pool_r <= in_pool[PW-1:0];
      pool_bad_r <= (32'(in_pool) >= NUM_POOLS);
      key_r <= in_key;
      nx_r <= cur_nx;
      cn_r <= cur_cn;
      gr_r <= '0;
    end
    if (cmd.srch_init) begin
      lo_r <= '0;
      hi_r <= cn_r;
    end
    if (cmd.srch_step) begin
      if (rdata > key_r) begin
        lo_r <= mid + 1'b1;
      end else begin
        hi_r <= mid;
      end
    end
    if (cmd.idx_init_ins) idx_r <= cn_r;
    if (cmd.idx_init_del) idx_r <= lo_r;
    if (cmd.idx_step_ins) idx_r <= idx_r - 1'b1;
    if (cmd.idx_step_del) idx_r <= idx_r + 1'b1;
    if (cmd.pop_take) begin
      gr_r <= rdata;
    end
  end

  logic [19:0] fin_nx;
  logic [CW-1:0] fin_cn;
  sfla_pkg::status_t fin_st;
  logic [19:0] fin_gr;
  logic [20:0] live;

  always_comb begin
    fin_nx = nx_r;
    fin_cn = cn_r;
    fin_gr = gr_r;
    fin_st = sfla_pkg::ST_OK;
    if (cmd.commit) begin
      unique case (act_r)
        sfla_pkg::ACT_ALLOC: begin
          if (cn_r != '0) begin
            fin_cn = cn_r - 1'b1;
          end else begin
            fin_gr = nx_r;
            fin_nx = nx_r + 20'd1;
          end
        end
        sfla_pkg::ACT_RELEASE: begin
          if ({1'b0, key_r} + 21'd1 == {1'b0, nx_r}) begin
            fin_nx = nx_r - 20'd1;
          end else begin
            fin_cn = cn_r + 1'b1;
          end
        end
        sfla_pkg::ACT_CLAIM: fin_cn = cn_r - 1'b1;
        default: begin
          fin_cn = '0;
          if (key_r >= nx_r) fin_nx = key_r + 20'd1;
        end
      endcase
    end else if (st.early_valid) begin
      fin_st = st.early_status;
    end else if (act_r == sfla_pkg::ACT_RELEASE) begin
      if (st.found) begin
        fin_st = dup_r ? sfla_pkg::ST_DUP_REFUSED : sfla_pkg::ST_DUP_ERROR;
      end else begin
        fin_st = sfla_pkg::ST_FULL;
      end
    end else begin
      fin_st = sfla_pkg::ST_NOT_FOUND;
    end
    live = {1'b0, fin_nx} - 21'(fin_cn) - 21'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        nxt_r[p] <= 20'd1;
        cnt_r[p] <= '0;
      end
    end else if (cmd.commit) begin
      nxt_r[pool_r] <= fin_nx;
      cnt_r[pool_r] <= fin_cn;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (pool_bad_r) begin
        out_granted_key <= '0;
        out_live_count <= '0;
        out_next_key <= '0;
      end else begin
        out_granted_key <= fin_gr;
        out_live_count <= live[20] ? 20'd0 : live[19:0];
        out_next_key <= fin_nx;
      end
      out_status <= fin_st;
    end
  end

endmodule
